/* rtl/core/btss_pkg.sv */
package btss_pkg;

  // Build-time element cap; the effective limit from the max_entries register is clamped to this.
  localparam int unsigned MaxElements = 64;

  // Default position counter width.
  localparam int unsigned OffsetBitsDefault = 16;

  // Output queue depth; a power of two so the pointers wrap on their own.
  localparam int unsigned FifoDepth = 4;

  // Configuration register indexes.
  localparam logic [0:0] CfgWrapperMode = 1'b0;
  localparam logic [0:0] CfgMaxEntries  = 1'b1;

  localparam logic [6:0] MaxEntriesReset = 7'd64;

  // BER header constants.
  localparam logic [7:0]  TagLowMask   = 8'h1f;
  localparam logic [7:0]  MsbMask      = 8'h80;
  localparam logic [7:0]  LowSevenMask = 8'h7f;
  localparam logic [31:0] SequenceTag  = 32'd16;

  typedef enum logic [1:0] {
    StatClean   = 2'd0,
    StatHeader  = 2'd1,
    StatWrapper = 2'd2,
    StatLimit   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        record_type;
    logic        constructed;
    logic [31:0] tag_number;
    logic [31:0] value_length;
    logic [15:0] value_offset;
    logic [6:0]  element_count;
    logic [1:0]  end_status;
    logic        final_result;
  } out_t;

  // Records produced by one byte: zero, one or two.
  typedef struct packed {
    logic [1:0] cnt;
    out_t       rec0;
    out_t       rec1;
  } push_t;

endpackage

/* rtl/core/ber_tlv_sequence_splitter_core.sv */
// A byte's records are written into the registered output queue when the byte transfers.
// One byte per cycle while in_stall_o is low; a byte yields up to two records (element, summary),
//   queued in a 4-entry output queue drained one record per cycle while out_stall_i is low.
// Input stalls while the queue holds more than two records.
// Reset (rst_ni low, asynchronous): parser at buffer start, queue empty,
//   wrapper_mode 0, max_entries 64.
module ber_tlv_sequence_splitter_core #(
  parameter int unsigned OFFSET_BITS = btss_pkg::OffsetBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  btss_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output btss_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_index_i,
  input  logic [6:0]     cfg_wdata_i
);
  import btss_pkg::*;

  logic       wrap_mode_q;
  logic [6:0] max_ent_q;
  logic [6:0] limit;
  logic       in_fire;
  logic       full;
  push_t      push;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_mode_q <= 1'b0;
      max_ent_q   <= MaxEntriesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWrapperMode: wrap_mode_q <= cfg_wdata_i[0];
        CfgMaxEntries:  max_ent_q   <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // effective element limit
  assign limit = (32'(max_ent_q) < MaxElements) ? max_ent_q : 7'(MaxElements);

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  btss_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .in_item_i      (in_data_i),
    .wrapper_mode_i (wrap_mode_q),
    .entry_limit_i  (limit),
    .push_o         (push)
  );

  btss_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/core/btss_parser.sv */
module btss_parser #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  btss_pkg::in_t  in_item_i,
  input  logic           wrapper_mode_i,
  input  logic [6:0]     entry_limit_i,
  output btss_pkg::push_t push_o
);
  import btss_pkg::*;

  typedef enum logic [5:0] {
    PhIdent    = 6'b000001,
    PhTagMore  = 6'b000010,
    PhLenFirst = 6'b000100,
    PhLenMore  = 6'b001000,
    PhValue    = 6'b010000,
    PhDone     = 6'b100000
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   cons_q, cons_d;
  logic [31:0]            tag_q, tag_d;
  logic [31:0]            len_q, len_d;
  logic [6:0]             lbytes_q, lbytes_d;
  logic [31:0]            vleft_q, vleft_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [31:0]            region_q, region_d;
  logic                   inwrap_q, inwrap_d;
  logic [6:0]             ent_q, ent_d;
  status_e                stat_q, stat_d;
  logic                   fresh_q, fresh_d;
  logic                   hdrwrap_q, hdrwrap_d;
  logic [OFFSET_BITS-1:0] poff_q, poff_d;

  // One byte per transfer: header walk, value skip, and record build
  always_comb begin
    logic [7:0]  b;
    logic        end_here;
    logic        hdr_fin;
    logic        emit;
    logic [31:0] emit_len;
    logic [31:0] poff_ext;
    out_t        elem;
    out_t        summ;

    b         = in_item_i.data_byte;
    end_here  = in_item_i.last_byte;
    hdr_fin   = 1'b0;
    emit      = 1'b0;
    emit_len  = '0;
    elem      = '0;
    summ      = '0;

    phase_d   = phase_q;
    cons_d    = cons_q;
    tag_d     = tag_q;
    len_d     = len_q;
    lbytes_d  = lbytes_q;
    vleft_d   = vleft_q;
    pos_d     = pos_q;
    region_d  = region_q;
    inwrap_d  = inwrap_q;
    ent_d     = ent_q;
    stat_d    = stat_q;
    fresh_d   = fresh_q;
    hdrwrap_d = hdrwrap_q;
    poff_d    = poff_q;
    push_o    = '0;

    if (phase_q != PhDone) begin
      // wrapper region countdown
      if (inwrap_q) begin
        if (region_d != '0) region_d = region_d - 32'd1;
        if (region_d == '0) end_here = 1'b1;
      end

      unique case (phase_q)
        PhIdent: begin
          if (fresh_q && wrapper_mode_i) begin
            hdrwrap_d = 1'b1;
          end
          if (!(fresh_q && wrapper_mode_i) && (ent_q >= entry_limit_i)) begin
            phase_d = PhDone;
            stat_d  = StatLimit;
          end else begin
            cons_d = b[5];
            if ((b & TagLowMask) == TagLowMask) begin
              tag_d   = '0;
              phase_d = PhTagMore;
            end else begin
              tag_d   = 32'(b & TagLowMask);
              phase_d = PhLenFirst;
            end
          end
        end
        PhTagMore: begin
          tag_d = {tag_q[24:0], b[6:0]};
          if (!b[7]) phase_d = PhLenFirst;
        end
        PhLenFirst: begin
          if (b == MsbMask) begin
            phase_d = PhDone;
            stat_d  = hdrwrap_q ? StatWrapper : StatHeader;
          end else if (b[7]) begin
            len_d    = '0;
            lbytes_d = b[6:0];
            if (b[6:0] == '0) hdr_fin = 1'b1;
            else              phase_d = PhLenMore;
          end else begin
            len_d   = 32'(b);
            hdr_fin = 1'b1;
          end
        end
        PhLenMore: begin
          len_d    = {len_q[23:0], b};
          lbytes_d = lbytes_q - 7'd1;
          if (lbytes_d == '0) hdr_fin = 1'b1;
        end
        PhValue: begin
          if (vleft_d != '0) vleft_d = vleft_d - 32'd1;
          if (vleft_d == '0) begin
            emit     = 1'b1;
            emit_len = len_q;
          end
        end
        default: begin
          phase_d = PhDone;
        end
      endcase

      // header complete: wrapper check or element setup
      if (hdr_fin) begin
        if (hdrwrap_q) begin
          hdrwrap_d = 1'b0;
          if (!cons_d || tag_d != SequenceTag) begin
            phase_d = PhDone;
            stat_d  = StatWrapper;
          end else begin
            inwrap_d = 1'b1;
            region_d = len_d;
            phase_d  = PhIdent;
            if (len_d == '0) begin
              phase_d = PhDone;
              stat_d  = StatClean;
            end
          end
        end else begin
          if (inwrap_d && len_d > region_d) len_d = region_d;
          vleft_d = len_d;
          poff_d  = pos_q + OFFSET_BITS'(1);
          if (len_d == '0) begin
            emit     = 1'b1;
            emit_len = '0;
          end else begin
            phase_d = PhValue;
          end
        end
      end

      // element record after its value
      if (emit) begin
        ent_d   = ent_d + 7'd1;
        phase_d = PhIdent;
        if (ent_d >= entry_limit_i) begin
          phase_d = PhDone;
          stat_d  = StatLimit;
        end
      end

      // region or buffer end
      if (end_here && phase_d != PhDone) begin
        if (phase_d == PhValue) begin
          emit     = 1'b1;
          emit_len = len_d - vleft_d;
          ent_d    = ent_d + 7'd1;
          stat_d   = (ent_d >= entry_limit_i) ? StatLimit : StatClean;
        end else if (phase_d != PhIdent) begin
          stat_d = hdrwrap_d ? StatWrapper : StatHeader;
        end else begin
          stat_d = StatClean;
        end
        phase_d = PhDone;
      end
      fresh_d = 1'b0;
    end
    pos_d = pos_q + OFFSET_BITS'(1);

    poff_ext           = 32'(poff_d);
    elem.record_type   = 1'b0;
    elem.constructed   = cons_d;
    elem.tag_number    = tag_d;
    elem.value_length  = emit_len;
    elem.value_offset  = poff_ext[15:0];
    elem.final_result  = !in_item_i.last_byte;

    summ.record_type   = 1'b1;
    summ.element_count = ent_d;
    summ.end_status    = stat_d;
    summ.final_result  = 1'b1;

    // record selection
    if (emit) begin
      push_o.rec0 = elem;
      push_o.rec1 = summ;
      push_o.cnt  = in_item_i.last_byte ? 2'd2 : 2'd1;
    end else if (in_item_i.last_byte) begin
      push_o.rec0 = summ;
      push_o.cnt  = 2'd1;
    end

    // fresh start after the summary
    if (in_item_i.last_byte) begin
      phase_d   = PhIdent;
      cons_d    = 1'b0;
      tag_d     = '0;
      len_d     = '0;
      lbytes_d  = '0;
      vleft_d   = '0;
      pos_d     = '0;
      region_d  = '0;
      inwrap_d  = 1'b0;
      ent_d     = '0;
      stat_d    = StatClean;
      fresh_d   = 1'b1;
      hdrwrap_d = 1'b0;
      poff_d    = '0;
    end

    if (!in_fire_i) push_o.cnt = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdent;
      cons_q    <= 1'b0;
      tag_q     <= '0;
      len_q     <= '0;
      lbytes_q  <= '0;
      vleft_q   <= '0;
      pos_q     <= '0;
      region_q  <= '0;
      inwrap_q  <= 1'b0;
      ent_q     <= '0;
      stat_q    <= StatClean;
      fresh_q   <= 1'b1;
      hdrwrap_q <= 1'b0;
      poff_q    <= '0;
    end else if (in_fire_i) begin
      phase_q   <= phase_d;
      cons_q    <= cons_d;
      tag_q     <= tag_d;
      len_q     <= len_d;
      lbytes_q  <= lbytes_d;
      vleft_q   <= vleft_d;
      pos_q     <= pos_d;
      region_q  <= region_d;
      inwrap_q  <= inwrap_d;
      ent_q     <= ent_d;
      stat_q    <= stat_d;
      fresh_q   <= fresh_d;
      hdrwrap_q <= hdrwrap_d;
      poff_q    <= poff_d;
    end
  end

endmodule

/* rtl/core/btss_out_fifo.sv */
module btss_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  btss_pkg::push_t push_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output btss_pkg::out_t  out_data_o
);
  import btss_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  out_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wp1;
  logic            pop;

  assign wp1         = wp_q + PtrW'(1);
  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  // room for two records is kept free ahead of every input transfer
  assign full_o      = (cnt_q > CntW'(FifoDepth - 2));

  // pointer and fill count update
  always_comb begin
    wp_d  = wp_q + PtrW'(push_i.cnt);
    rp_d  = pop ? rp_q + PtrW'(1) : rp_q;
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // record storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FifoDepth; i++) begin
      if (push_i.cnt != 2'd0 && wp_q == PtrW'(i)) begin
        mem_q[i] <= push_i.rec0;
      end else if (push_i.cnt == 2'd2 && wp1 == PtrW'(i)) begin
        mem_q[i] <= push_i.rec1;
      end
    end
  end

endmodule

/* bench/tb_ber_tlv_sequence_splitter_core.sv */
module tb_ber_tlv_sequence_splitter_core;
  import btss_pkg::*;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    SpIdent,
    SpTagMore,
    SpLenFirst,
    SpLenMore,
    SpValue,
    SpDone
  } split_phase_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_we    = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [6:0] cfg_wdata = '0;

  ber_tlv_sequence_splitter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // Predictor copy of the registers
  logic       cfg_wrap = 1'b0;
  logic [6:0] cfg_max  = MaxEntriesReset;

  // Predictor parse state
  split_phase_e ph;
  logic         el_con;
  logic [31:0]  tag_acc;
  logic [31:0]  len_acc;
  logic [6:0]   len_left;
  logic [31:0]  val_left;
  logic [15:0]  pos;
  logic [31:0]  region_left;
  logic         in_wrap;
  logic [6:0]   found;
  status_e      stop_st;
  logic         fresh;
  logic         hdr_wrap;
  logic [15:0]  pend_off;

  // Records produced by the byte being predicted
  out_t step_recs [2];
  int   step_n;

  in_t        byte_q   [$];
  out_t       record_q [$];
  logic [7:0] frame    [$];

  int mismatch_cnt = 0;
  int records_seen = 0;
  int bytes_queued = 0;
  int idle_pct     = 0;
  bit byte_taken   = 1'b0;
  int tx_gap       = 0;
  int rx_gap       = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic int entry_cap();
    return (int'(cfg_max) < int'(MaxElements)) ? int'(cfg_max) : int'(MaxElements);
  endfunction

  function automatic void restart_parse();
    ph          = SpIdent;
    el_con      = 1'b0;
    tag_acc     = '0;
    len_acc     = '0;
    len_left    = '0;
    val_left    = '0;
    pos         = '0;
    region_left = '0;
    in_wrap     = 1'b0;
    found       = '0;
    stop_st     = StatClean;
    fresh       = 1'b1;
    hdr_wrap    = 1'b0;
    pend_off    = '0;
  endfunction

  function automatic void halt(input status_e s);
    ph      = SpDone;
    stop_st = s;
  endfunction

  function automatic void emit_elem(input logic [31:0] len);
    out_t r;
    r              = '0;
    r.constructed  = el_con;
    r.tag_number   = tag_acc;
    r.value_length = len;
    r.value_offset = pend_off;
    r.final_result = 1'b1;
    step_recs[step_n] = r;
    step_n++;
    found = found + 7'd1;
    ph    = SpIdent;
    if (int'(found) >= entry_cap()) halt(StatLimit);
  endfunction

  // Length known: enter the wrapper, or open an element value
  function automatic void finish_header();
    logic [31:0] len;
    len = len_acc;
    if (hdr_wrap) begin
      hdr_wrap = 1'b0;
      if (!el_con || tag_acc != SequenceTag) begin
        halt(StatWrapper);
        return;
      end
      in_wrap     = 1'b1;
      region_left = len;
      ph          = SpIdent;
      if (len == 0) halt(StatClean);
      return;
    end
    if (in_wrap && len > region_left) len = region_left;
    len_acc  = len;
    val_left = len;
    pend_off = pos + 16'd1;
    if (len == 0) emit_elem('0);
    else ph = SpValue;
  endfunction

  // Works out the records one accepted byte causes and queues them
  task automatic split_byte(input in_t tlv_byte);
    logic [7:0] b;
    logic       end_here;
    out_t       summ;
    b      = tlv_byte.data_byte;
    step_n = 0;
    if (ph != SpDone) begin
      end_here = tlv_byte.last_byte;
      if (in_wrap) begin
        if (region_left > 0) region_left--;
        if (region_left == 0) end_here = 1'b1;
      end
      case (ph)
        SpIdent: begin
          if (!(fresh && cfg_wrap) && int'(found) >= entry_cap()) begin
            halt(StatLimit);
          end else begin
            if (fresh && cfg_wrap) hdr_wrap = 1'b1;
            el_con = b[5];
            if ((b & TagLowMask) == TagLowMask) begin
              tag_acc = '0;
              ph      = SpTagMore;
            end else begin
              tag_acc = {27'd0, b[4:0]};
              ph      = SpLenFirst;
            end
          end
        end
        SpTagMore: begin
          tag_acc = {tag_acc[24:0], b[6:0]};
          if (!b[7]) ph = SpLenFirst;
        end
        SpLenFirst: begin
          if (b == MsbMask) begin
            halt(hdr_wrap ? StatWrapper : StatHeader);
          end else if (b[7]) begin
            len_acc  = '0;
            len_left = b[6:0];
            if (len_left == 0) finish_header();
            else ph = SpLenMore;
          end else begin
            len_acc = {24'd0, b};
            finish_header();
          end
        end
        SpLenMore: begin
          len_acc  = {len_acc[23:0], b};
          len_left = len_left - 7'd1;
          if (len_left == 0) finish_header();
        end
        SpValue: begin
          if (val_left > 0) val_left--;
          if (val_left == 0) emit_elem(len_acc);
        end
        default: ;
      endcase
      // buffer or wrapper region ends on this byte
      if (end_here && ph != SpDone) begin
        if (ph == SpValue) emit_elem(len_acc - val_left);
        else if (ph != SpIdent) halt(hdr_wrap ? StatWrapper : StatHeader);
        if (ph != SpDone) halt(StatClean);
      end
      fresh = 1'b0;
    end
    pos = pos + 16'd1;
    if (tlv_byte.last_byte) begin
      if (step_n > 0) step_recs[step_n-1].final_result = 1'b0;
      summ               = '0;
      summ.record_type   = 1'b1;
      summ.element_count = found;
      summ.end_status    = stop_st;
      summ.final_result  = 1'b1;
      step_recs[step_n]  = summ;
      step_n++;
      restart_parse();
    end
    for (int i = 0; i < step_n; i++) record_q.push_back(step_recs[i]);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("record %0d %s: got 0x%0h, want 0x%0h",
                              records_seen, name, got, want));
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  // Short or long form length, long form sometimes padded with zero bytes
  task automatic put_len(input int unsigned n, input bit long_form);
    int          k;
    int          pad;
    logic [31:0] nv;
    logic [7:0]  cnt_b;
    nv = n;
    if (!long_form && n < 128) begin
      frame.push_back(nv[7:0]);
    end else begin
      k     = (n > 32'hFFFFFF) ? 4 : (n > 32'hFFFF) ? 3 : (n > 32'hFF) ? 2 : 1;
      pad   = ($urandom_range(7, 0) == 0) ? $urandom_range(3, 1) : 0;
      cnt_b = MsbMask | 8'(k + pad);
      frame.push_back(cnt_b);
      repeat (pad) frame.push_back(8'h00);
      for (int s = k - 1; s >= 0; s--) frame.push_back(nv[8*s +: 8]);
    end
  endtask

  // One well-formed element with random identifier, tag form and value
  task automatic put_elem();
    logic [7:0] ident;
    logic [7:0] t;
    int         nb;
    int         vlen;
    ident = rand_byte();
    if ($urandom_range(3, 0) != 0) begin
      if (ident[4:0] == 5'h1f) ident[0] = 1'b0;
      frame.push_back(ident);
    end else begin
      ident[4:0] = 5'h1f;
      frame.push_back(ident);
      nb = $urandom_range(6, 1);
      for (int j = 0; j < nb; j++) begin
        t    = rand_byte();
        t[7] = (j != nb - 1);
        frame.push_back(t);
      end
    end
    vlen = ($urandom_range(15, 0) == 0) ? $urandom_range(200, 0) : $urandom_range(6, 0);
    put_len(vlen, $urandom_range(3, 0) == 0);
    repeat (vlen) frame.push_back(rand_byte());
  endtask

  task automatic ship_frame();
    in_t tlv_byte;
    foreach (frame[i]) begin
      tlv_byte.data_byte = frame[i];
      tlv_byte.last_byte = (i == frame.size() - 1);
      byte_q.push_back(tlv_byte);
      bytes_queued++;
    end
    frame.delete();
  endtask

  // flavor 0: well formed, 1: broken (indefinite, bad wrapper, truncated), 2: noise
  task automatic build_buffer(input int flavor);
    logic [7:0] inner [$];
    logic [7:0] ident;
    logic [7:0] rb;
    int         cnt;
    int         kind;
    int         wlen;
    int         cut;
    kind = (flavor == 1) ? $urandom_range(2, 0) : -1;
    if (kind == 1 && !cfg_wrap) kind = 2;
    frame.delete();
    if (flavor == 2) begin
      repeat ($urandom_range(12, 1)) frame.push_back(rand_byte());
    end else begin
      cnt = $urandom_range(5, cfg_wrap ? 0 : 1);
      repeat (cnt) put_elem();
      if (kind == 0) begin
        frame.push_back(8'h04);
        frame.push_back(MsbMask);
        put_elem();
      end
      if (cfg_wrap) begin
        inner = frame;
        frame.delete();
        ident      = rand_byte();
        ident[5:0] = 6'h30;
        if (kind == 1) begin
          rb = rand_byte();
          if (rb[7]) begin
            ident[5] = 1'b0;
          end else begin
            ident[4]   = 1'b0;
            ident[3:0] = rb[3:0];
          end
        end
        // wrapper tag sometimes in multi-byte form
        if ($urandom_range(5, 0) == 0 && ident[4:0] == 5'h10) begin
          ident[4:0] = 5'h1f;
          frame.push_back(ident);
          frame.push_back(8'h10);
        end else begin
          frame.push_back(ident);
        end
        wlen = inner.size();
        case ($urandom_range(7, 0))
          0:       wlen = $urandom_range(wlen, 0);
          1:       wlen = wlen + $urandom_range(3, 1);
          default: ;
        endcase
        put_len(wlen, $urandom_range(3, 0) == 0);
        foreach (inner[i]) frame.push_back(inner[i]);
        if ($urandom_range(3, 0) == 0) repeat ($urandom_range(3, 1)) frame.push_back(rand_byte());
      end
      if (kind == 2 && frame.size() > 1) begin
        cut = $urandom_range(frame.size() - 1, 1);
        repeat (cut) frame.delete(frame.size() - 1);
      end
    end
    ship_frame();
  endtask

  task automatic wait_drain();
    while (byte_q.size() != 0 || in_valid || record_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CfgWrapperMode) cfg_wrap = val[0];
    else cfg_max = val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Registers change only with the block idle
  task automatic configure(input logic wrap, input logic [6:0] max_ent, input int idle);
    wait_drain();
    repeat (4) @(negedge clk_i);
    write_reg(CfgWrapperMode, {6'd0, wrap});
    write_reg(CfgMaxEntries, max_ent);
    @(posedge clk_i);
    idle_pct = idle;
  endtask

  task automatic run_phase(input logic wrap, input logic [6:0] max_ent, input int idle,
                           input int target);
    int first;
    int sel;
    configure(wrap, max_ent, idle);
    first = bytes_queued;
    while (bytes_queued - first < target) begin
      sel = $urandom_range(19, 0);
      build_buffer(sel < 14 ? 0 : sel < 17 ? 1 : 2);
    end
  endtask

  // ---------------------------------------------------------------- clock, reset, limit

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  // New byte offered once the previous transfer happened or nothing was offered
  always @(negedge clk_i) begin
    if (!in_valid || byte_taken) begin
      if (tx_gap == 0 && idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        tx_gap = $urandom_range(18, 1);
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_data  <= byte_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    byte_taken = 1'b0;
  end

  // Receiver stall: random bursts, plus one long hold-off while bytes are offered
  always @(negedge clk_i) begin
    if (!hold_done && records_seen >= 80 && in_valid) begin
      hold_left = 250;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_gap == 0 && idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        rx_gap = $urandom_range(18, 1);
      if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : monitor
    out_t want;
    out_t got;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        byte_taken = 1'b1;
        split_byte(in_data);
      end
      if (out_valid && !out_stall) begin
        records_seen++;
        got = out_data;
        if (record_q.size() == 0) begin
          flag_mismatch($sformatf("record %0d arrived with nothing expected", records_seen));
        end else begin
          want = record_q.pop_front();
          check_field("record_type", 32'(got.record_type), 32'(want.record_type));
          check_field("constructed", 32'(got.constructed), 32'(want.constructed));
          check_field("tag_number", got.tag_number, want.tag_number);
          check_field("value_length", got.value_length, want.value_length);
          check_field("value_offset", 32'(got.value_offset), 32'(want.value_offset));
          check_field("element_count", 32'(got.element_count), 32'(want.element_count));
          check_field("end_status", 32'(got.end_status), 32'(want.end_status));
          check_field("final_result", 32'(got.final_result), 32'(want.final_result));
        end
      end
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin : stim
    logic [7:0] rb;
    logic [6:0] mx;
    logic       w;
    restart_parse();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: byte extremes, long and over-long length forms, value cut by buffer end
    configure(1'b0, 7'd64, 20);
    frame = '{8'hFF, 8'h7F, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
              8'h04, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF,
              8'h04, 8'h05, 8'h01};
    ship_frame();
    // indefinite length
    frame = '{8'h04, 8'h80};
    ship_frame();
    // header cut short by buffer end
    frame = '{8'h1F, 8'h81};
    ship_frame();

    // wrapper: inner length clamped to region, trailing byte ignored
    configure(1'b1, 7'd64, 20);
    frame = '{8'h30, 8'h03, 8'h04, 8'h05, 8'h01, 8'hEE};
    ship_frame();
    // primitive wrapper is rejected
    frame = '{8'h10, 8'h00};
    ship_frame();

    // entry limit of one
    configure(1'b0, 7'd1, 0);
    frame = '{8'h05, 8'h00, 8'h05};
    ship_frame();

    // random buffers under several settings
    run_phase(1'b0, 7'd64, 10, 150);
    run_phase(1'b1, 7'd64, 25, 150);
    run_phase(1'b0, 7'd2, 0, 120);
    run_phase(1'b1, 7'd3, 10, 120);
    rb = rand_byte();
    w  = rb[7];
    mx = {1'b0, rb[5:0]} + 7'd1;
    run_phase(w, mx, 15, 150);
    run_phase(1'b1, 7'd1, 10, 80);

    // last part without idling
    run_phase(1'b0, 7'd64, 0, 130);

    wait_drain();
    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
